@@ rtl/ieee_float_decode_classify_assert.svh @@
// assertion macros used by the checker file fdc_chk.sv
`ifndef IEEE_FLOAT_DECODE_CLASSIFY_ASSERT_SVH
`define IEEE_FLOAT_DECODE_CLASSIFY_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FDC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fdc_pkg.sv @@
package fdc_pkg;

	// field widths of the two formats
	localparam int unsigned D_FRAC_W = 52;
	localparam int unsigned S_FRAC_W = 23;
	localparam int unsigned D_EXP_W  = 11;
	localparam int unsigned S_EXP_W  = 8;

	// result widths
	localparam int unsigned MANT_W = D_FRAC_W + 1;
	localparam int unsigned EXP_W  = 12;
	localparam int unsigned LZ_W   = 6;

	// single fraction is carried left aligned in the double fraction field
	localparam int unsigned ALIGN_SH = D_FRAC_W - S_FRAC_W;

	// exponent field offsets (bias plus fraction width)
	localparam logic signed [EXP_W:0] D_BIAS = 13'sd1075;
	localparam logic signed [EXP_W:0] S_BIAS = 13'sd150;

	localparam logic [D_EXP_W-1:0] D_EXP_ONES = 11'h7ff;
	localparam logic [S_EXP_W-1:0] S_EXP_ONES = 8'hff;

	typedef enum logic {
		FMT_DOUBLE = 1'b0,
		FMT_SINGLE = 1'b1
	} fmt_t;

	// classification bits carried down the pipeline
	typedef struct packed {
		fmt_t fmt;
		logic sgn;
		logic ezero;
		logic eones;
		logic fzero;
	} cls_t;

endpackage

@@ rtl/fdc_lzc.sv @@
module fdc_lzc import fdc_pkg::*; (
	input  logic [D_FRAC_W-1:0] frac,
	output logic [LZ_W-1:0]     count
);

	localparam int unsigned GRP_W  = 8;
	localparam int unsigned NGRP   = (D_FRAC_W + GRP_W - 1) / GRP_W;
	localparam int unsigned PAD_W  = NGRP * GRP_W;
	localparam int unsigned GLZ_W  = $clog2(GRP_W);

	logic [PAD_W-1:0] padded;
	logic [GRP_W-1:0] grp [NGRP];
	logic [GLZ_W-1:0] glz [NGRP];
	logic [NGRP-1:0]  nz;

	// left aligned, zero fill at the bottom
	assign padded = {frac, {(PAD_W - D_FRAC_W){1'b0}}};

	// leading zeros inside each byte group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp[g] = padded[PAD_W - 1 - g * GRP_W -: GRP_W];
			nz[g]  = |grp[g];
			glz[g] = '0;
			for (int b = 0; b < GRP_W; b++) begin
				if (grp[g][b]) begin
					glz[g] = GLZ_W'(GRP_W - 1 - b);
				end
			end
		end
	end

	// first nonzero group from the top wins
	always_comb begin
		count = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (nz[g]) begin
				count = LZ_W'(g * GRP_W) + LZ_W'(glz[g]);
			end
		end
	end

endmodule

@@ rtl/ieee_float_decode_classify.sv @@
// IEEE-754 decode and classify unit.
// Input channel op_valid/op_ready carries cmd (0 double, 1 single in the low
// 32 bits of value_bits) and the raw bit pattern. Output channel
// res_valid/res_ready returns sign, integer mantissa and binary exponent with
// value = (-1)^sign * mantissa * 2^exponent, plus zero, NaN, infinity,
// exponent-field-zero and negative-zero flags. Denormals come out normalized;
// infinity and NaN decode as ordinary numbers and only the flags mark them.
// Field unpack goes into the first register, the leading zero count over the
// 52-bit fraction into the second, then the normalizing shift and exponent
// adjust into the output register. One item per cycle is accepted while the
// output is taken every cycle.
// When the receiver stalls, the result holds in the output register and each
// stage keeps loading while a bubble lies ahead of it, so the pipeline fills
// up before op_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits, which keeps op_ready high, so the block is
// ready as soon as reset is released.
module ieee_float_decode_classify import fdc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    op_valid,
	output logic                    op_ready,
	input  logic                    cmd,
	input  logic [63:0]             value_bits,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic                    sign,
	output logic [MANT_W-1:0]       mantissa,
	output logic signed [EXP_W-1:0] exponent,
	output logic                    is_zero,
	output logic                    is_nan,
	output logic                    is_infinite,
	output logic                    is_exponent_zero,
	output logic                    is_negative_zero
);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	// unpack signals
	fmt_t                fmt_in;
	logic [D_EXP_W-1:0]  efield_in;
	logic [D_FRAC_W-1:0] frac_in;
	cls_t                cls_in;

	logic [D_EXP_W-1:0]  efield_s1, efield_s2;
	logic [D_FRAC_W-1:0] frac_s1, frac_s2;
	cls_t                cls_s1, cls_s2, cls_s3;
	logic [LZ_W-1:0]     lz_cnt, lz_s2;

	logic [MANT_W-1:0]       mant_s3;
	logic signed [EXP_W-1:0] exp_s3;

	// stage 3 datapath
	logic signed [EXP_W:0] bias;
	logic signed [EXP_W:0] exp_full;
	logic [MANT_W-1:0]     shifted;
	logic [MANT_W-1:0]     mant_nxt;
	logic                  zero_nxt;

	// stage enables: a stage loads when empty or when the next one loads
	assign en3      = !v_s3 || res_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign op_ready = en1;

	// field unpack
	always_comb begin
		fmt_in = fmt_t'(cmd);
		cls_in.fmt = fmt_in;
		if (fmt_in == FMT_SINGLE) begin
			efield_in    = {{(D_EXP_W - S_EXP_W){1'b0}}, value_bits[30:23]};
			frac_in      = {value_bits[S_FRAC_W-1:0], {ALIGN_SH{1'b0}}};
			cls_in.sgn   = value_bits[31];
			cls_in.eones = (value_bits[30:23] == S_EXP_ONES);
		end else begin
			efield_in    = value_bits[62:52];
			frac_in      = value_bits[D_FRAC_W-1:0];
			cls_in.sgn   = value_bits[63];
			cls_in.eones = (value_bits[62:52] == D_EXP_ONES);
		end
		cls_in.ezero = (efield_in == '0);
		cls_in.fzero = (frac_in == '0);
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && op_valid) begin
			efield_s1 <= efield_in;
			frac_s1   <= frac_in;
			cls_s1    <= cls_in;
		end
	end

	// leading zero count of the aligned fraction
	fdc_lzc u_lzc (
		.frac  (frac_s1),
		.count (lz_cnt)
	);

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			efield_s2 <= efield_s1;
			frac_s2   <= frac_s1;
			cls_s2    <= cls_s1;
			lz_s2     <= lz_cnt;
		end
	end

	// normalize and compute exponent
	always_comb begin
		bias     = (cls_s2.fmt == FMT_SINGLE) ? S_BIAS : D_BIAS;
		zero_nxt = cls_s2.ezero && cls_s2.fzero;
		if (zero_nxt) begin
			shifted  = '0;
			exp_full = '0;
		end else if (cls_s2.ezero) begin
			shifted  = {1'b0, frac_s2} << ((LZ_W + 1)'(lz_s2) + (LZ_W + 1)'(1));
			exp_full = -bias - $signed({1'b0, {(EXP_W - LZ_W){1'b0}}, lz_s2});
		end else begin
			shifted  = {1'b1, frac_s2};
			exp_full = $signed({2'b00, efield_s2}) - bias;
		end
		mant_nxt = (cls_s2.fmt == FMT_SINGLE) ? (shifted >> ALIGN_SH) : shifted;
	end

	// stage 3 output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			mant_s3 <= mant_nxt;
			exp_s3  <= exp_full[EXP_W-1:0];
			cls_s3  <= cls_s2;
		end
	end

	// result fields
	assign res_valid        = v_s3;
	assign mantissa         = mant_s3;
	assign exponent         = exp_s3;
	assign is_zero          = cls_s3.ezero && cls_s3.fzero;
	assign sign             = cls_s3.sgn && !is_zero;
	assign is_nan           = cls_s3.eones && !cls_s3.fzero;
	assign is_infinite      = cls_s3.eones && cls_s3.fzero;
	assign is_exponent_zero = cls_s3.ezero;
	assign is_negative_zero = is_zero && cls_s3.sgn;

endmodule

@@ rtl/fdc_chk.sv @@
`include "ieee_float_decode_classify_assert.svh"

module fdc_chk import fdc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic                    sign,
	input logic [MANT_W-1:0]       mantissa,
	input logic signed [EXP_W-1:0] exponent,
	input logic                    is_zero,
	input logic                    is_nan,
	input logic                    is_infinite,
	input logic                    is_exponent_zero,
	input logic                    is_negative_zero
);

	// a stalled result holds
	`FDC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(mantissa) && $stable(exponent) && $stable(sign), "stalled item changed")

	// zero decodes to all-zero fields
	`FDC_ASSERT_NOW(a_zero_fields, clk, arst_n, res_valid && is_zero, !sign && mantissa == '0 && exponent == '0, "zero item has nonzero fields")

	// nonzero results carry the hidden bit of one of the formats
	`FDC_ASSERT_NOW(a_hidden_bit, clk, arst_n, res_valid && !is_zero, mantissa[52] || (mantissa[23] && mantissa[52:24] == '0), "mantissa not normalized")

	// special flags exclude each other and the zero classes
	`FDC_ASSERT_NOW(a_special_flags, clk, arst_n, res_valid && (is_nan || is_infinite), !(is_nan && is_infinite) && !is_exponent_zero && !is_zero, "conflicting class flags")

	// negative zero is a zero with an exponent field of zero
	`FDC_ASSERT_NOW(a_neg_zero, clk, arst_n, res_valid && is_negative_zero, is_zero && is_exponent_zero, "negative zero without zero flag")

endmodule

bind ieee_float_decode_classify fdc_chk u_fdc_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res_valid),
	.res_ready        (res_ready),
	.sign             (sign),
	.mantissa         (mantissa),
	.exponent         (exponent),
	.is_zero          (is_zero),
	.is_nan           (is_nan),
	.is_infinite      (is_infinite),
	.is_exponent_zero (is_exponent_zero),
	.is_negative_zero (is_negative_zero)
);

@@ verif/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fdc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic                    sign;
		logic [MANT_W-1:0]       mant;
		logic signed [EXP_W-1:0] expo;
		logic                    zero;
		logic                    nan;
		logic                    inf;
		logic                    ezero;
		logic                    negzero;
	} float_fields_t;

	logic                    clk;
	logic                    arst_n;
	logic                    op_valid;
	logic                    op_ready;
	logic                    cmd;
	logic [63:0]             value_bits;
	logic                    res_valid;
	logic                    res_ready;
	logic                    sign;
	logic [MANT_W-1:0]       mantissa;
	logic signed [EXP_W-1:0] exponent;
	logic                    is_zero;
	logic                    is_nan;
	logic                    is_infinite;
	logic                    is_exponent_zero;
	logic                    is_negative_zero;

	float_fields_t pending_decodes[$];
	int            errors = 0;
	int            cycles = 0;
	bit            src_steady = 0;
	bit            snk_steady = 0;

	ieee_float_decode_classify dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.op_valid         (op_valid),
		.op_ready         (op_ready),
		.cmd              (cmd),
		.value_bits       (value_bits),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.sign             (sign),
		.mantissa         (mantissa),
		.exponent         (exponent),
		.is_zero          (is_zero),
		.is_nan           (is_nan),
		.is_infinite      (is_infinite),
		.is_exponent_zero (is_exponent_zero),
		.is_negative_zero (is_negative_zero)
	);

	// clock, first rising edge half a period after start
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// expected decode of one bit pattern
	function automatic float_fields_t decode_float(fmt_t fmt, logic [63:0] raw);
		float_fields_t r;
		logic [63:0]   hidden;
		logic [63:0]   frac;
		logic [63:0]   mant;
		int            efield;
		int            emax;
		int            bias;
		int            ex;
		logic          sbit;
		logic          zero;
		if (fmt == FMT_DOUBLE) begin
			hidden = 64'd1 << D_FRAC_W;
			efield = raw[62:52];
			emax = D_EXP_ONES;
			bias = D_BIAS;
			sbit = raw[63];
		end else begin
			hidden = 64'd1 << S_FRAC_W;
			efield = raw[30:23];
			emax = S_EXP_ONES;
			bias = S_BIAS;
			sbit = raw[31];
		end
		frac = raw & (hidden - 64'd1);
		zero = (efield == 0) && (frac == 64'd0);
		mant = 64'd0;
		ex = 0;
		if (!zero) begin
			ex = efield - bias;
			if (efield != 0) begin
				mant = frac | hidden;
			end else begin
				// denormal: shift up to the hidden bit position
				mant = frac;
				ex = ex + 1;
				while ((mant & hidden) == 64'd0) begin
					mant = mant << 1;
					ex = ex - 1;
				end
			end
		end
		r.sign = zero ? 1'b0 : sbit;
		r.mant = mant[MANT_W-1:0];
		r.expo = ex[EXP_W-1:0];
		r.zero = zero;
		r.nan = (efield == emax) && (frac != 64'd0);
		r.inf = (efield == emax) && (frac == 64'd0);
		r.ezero = (efield == 0);
		r.negzero = zero && sbit;
		return r;
	endfunction

	function automatic int idle_cycles(bit steady);
		if (steady || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// send one item, called at a rising edge, returns at its acceptance edge
	task automatic send_item(fmt_t fmt, logic [63:0] raw);
		int gap;
		gap = idle_cycles(src_steady);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		cmd <= fmt;
		value_bits <= raw;
		do @(posedge clk); while (!op_ready);
		pending_decodes.push_back(decode_float(fmt, raw));
	endtask

	// random pattern biased toward zeros, denormals, extremes and NaN/inf
	task automatic send_random(fmt_t fmt);
		logic [63:0] fr;
		logic [63:0] mask;
		logic [63:0] raw;
		int          fw;
		int          emax;
		int          e;
		logic        s;
		fw = (fmt == FMT_DOUBLE) ? D_FRAC_W : S_FRAC_W;
		emax = (fmt == FMT_DOUBLE) ? D_EXP_ONES : S_EXP_ONES;
		mask = (64'd1 << fw) - 64'd1;
		case ($urandom_range(0, 5))
			0: fr = 64'd0;
			1: fr = 64'd1 << $urandom_range(0, fw - 1);
			2: fr = mask;
			3, 4: fr = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: fr = {$urandom, $urandom};
		endcase
		fr = fr & mask;
		case ($urandom_range(0, 7))
			0: e = 0;
			1: e = emax;
			2: e = 1;
			3: e = emax - 1;
			default: e = $urandom_range(0, emax);
		endcase
		s = $urandom_range(0, 1);
		if (fmt == FMT_DOUBLE)
			raw = {s, e[10:0], fr[51:0]};
		else
			raw = {$urandom, s, e[7:0], fr[22:0]};
		send_item(fmt, raw);
	endtask

	// zeros, denormal extremes, normal extremes, infinities and NaNs
	task automatic test_special_values();
		send_item(FMT_DOUBLE, 64'h0000_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h8000_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h0000_0000_0000_0001);
		send_item(FMT_DOUBLE, 64'h000f_ffff_ffff_ffff);
		send_item(FMT_DOUBLE, 64'h8008_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h0010_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h7fef_ffff_ffff_ffff);
		send_item(FMT_DOUBLE, 64'hbff0_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h7ff0_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'hfff0_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h7ff8_0000_0000_0000);
		send_item(FMT_DOUBLE, 64'h7ff0_0000_0000_0001);
		send_item(FMT_DOUBLE, 64'hffff_ffff_ffff_ffff);
		send_item(FMT_SINGLE, 64'h0000_0000_0000_0000);
		send_item(FMT_SINGLE, 64'h0000_0000_8000_0000);
		// upper half ignored in single format
		send_item(FMT_SINGLE, 64'h5a5a_a5a5_8000_0000);
		send_item(FMT_SINGLE, 64'h0000_0000_0000_0001);
		send_item(FMT_SINGLE, 64'hffff_ffff_807f_ffff);
		send_item(FMT_SINGLE, 64'h0000_0000_0080_0000);
		send_item(FMT_SINGLE, 64'h0000_0000_7f7f_ffff);
		send_item(FMT_SINGLE, 64'h7ff0_0000_7f80_0000);
		send_item(FMT_SINGLE, 64'h0000_0000_ff80_0000);
		send_item(FMT_SINGLE, 64'h0000_0000_7fc0_0000);
		send_item(FMT_SINGLE, 64'hffff_ffff_ffff_ffff);
		send_item(FMT_SINGLE, 64'hffff_ffff_3f80_0000);
	endtask

	task automatic test_double_patterns(int count);
		repeat (count) send_random(FMT_DOUBLE);
	endtask

	task automatic test_single_patterns(int count);
		repeat (count) send_random(FMT_SINGLE);
	endtask

	// mixed formats, cycling through steady and stalling sides
	task automatic test_back_to_back(int count);
		for (int i = 0; i < count; i++) begin
			src_steady = ((i / 50) % 4) != 1;
			snk_steady = ((i / 50) % 4) < 2;
			send_random(fmt_t'($urandom_range(0, 1)));
		end
		src_steady = 0;
		snk_steady = 0;
	endtask

	// result side ready pattern
	initial begin
		int wait_n;
		res_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_n = idle_cycles(snk_steady);
			if (wait_n > 0) begin
				res_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
			errors++;
		end
	endtask

	// compare each result item with the oldest expected decode
	always @(posedge clk) begin
		float_fields_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_decodes.size() == 0) begin
				$display("%0t: unexpected result item, expected none, actual mantissa %0h",
					$realtime, mantissa);
				errors++;
			end else begin
				want = pending_decodes.pop_front();
				check_field("sign", want.sign, sign);
				check_field("mantissa", want.mant, mantissa);
				check_field("exponent", want.expo, exponent);
				check_field("is_zero", want.zero, is_zero);
				check_field("is_nan", want.nan, is_nan);
				check_field("is_infinite", want.inf, is_infinite);
				check_field("is_exponent_zero", want.ezero, is_exponent_zero);
				check_field("is_negative_zero", want.negzero, is_negative_zero);
			end
		end
	end

	// main sequence
	initial begin
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		cmd <= FMT_DOUBLE;
		value_bits <= 64'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_values();
		test_double_patterns(450);
		test_single_patterns(450);
		test_back_to_back(400);

		op_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
